// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/i2cmra_pkg.sv
// ---------------------------------------------------------------------------
// I2C register access package
// Command codes, bus phase encoding and item types for the I2C master.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cmra_pkg;

   // command codes
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_CMD   = 2'd3;

   // which byte a byte/ack phase belongs to
   localparam logic [1:0] GRP_ADDR  = 2'd0;
   localparam logic [1:0] GRP_REG   = 2'd1;
   localparam logic [1:0] GRP_RADDR = 2'd2;
   localparam logic [1:0] GRP_DATA  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [2:0]  LAST_BIT      = 3'd7;

   typedef enum logic [15:0] {
      PH_IDLE    = 16'h0001,
      PH_START   = 16'h0002,
      PH_BIT_LO  = 16'h0004,
      PH_BIT_HI  = 16'h0008,
      PH_ACK_LO  = 16'h0010,
      PH_ACK_HI  = 16'h0020,
      PH_RS_LO   = 16'h0040,
      PH_RS_HI   = 16'h0080,
      PH_RS_FALL = 16'h0100,
      PH_RD_LO   = 16'h0200,
      PH_RD_HI   = 16'h0400,
      PH_NK_LO   = 16'h0800,
      PH_NK_HI   = 16'h1000,
      PH_SP_LO   = 16'h2000,
      PH_SP_HI   = 16'h4000,
      PH_SP_RISE = 16'h8000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] device_address;
      logic [7:0] register_index;
      logic [7:0] write_data;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: sv/i2cmra_if.sv
// ---------------------------------------------------------------------------
// I2C register access channels
// Valid/ready channels for commands, per-tick results and the timeout CSR.
// ---------------------------------------------------------------------------
`default_nettype none

interface i2cmra_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] device_address;
   logic [7:0] register_index;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, kind, device_address, register_index, write_data, sda_in,
                   input ready);
   modport sink   (input valid, kind, device_address, register_index, write_data, sda_in,
                   output ready);
endinterface

interface i2cmra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_missing;

   modport source  (output valid, scl_out, sda_out, busy_res, done_res, read_data, ack_missing,
                    input ready);
   modport sink    (input valid, scl_out, sda_out, busy_res, done_res, read_data, ack_missing,
                    output ready);
   modport monitor (input valid, ready, scl_out, sda_out, busy_res, done_res, read_data,
                    ack_missing);
endinterface

interface i2cmra_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/i2cmra_engine.sv
// ---------------------------------------------------------------------------
// I2C register access engine
// Bus phase state and its single-tick next-state/line-drive logic.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cmra_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  i2cmra_pkg::req_item_type   item,
   input  logic [15:0]                ack_timeout,
   output i2cmra_pkg::rsp_item_type   result
);

   i2cmra_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  group_ff, group_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] wait_ff, wait_in;
   logic [1:0]  access_kind_ff, access_kind_in;
   logic [7:0]  address_ff, address_in;
   logic [7:0]  register_ff, register_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  received_ff, received_in;
   logic        error_ff, error_in;

   logic        scl, sda, done;
   logic [15:0] wait_inc;
   logic [7:0]  shift_rd;

   assign wait_inc = wait_ff + 16'd1;
   assign shift_rd = {shift_ff[6:0], item.sda_in};

   always_comb begin
      phase_in       = phase_ff;
      group_in       = group_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      wait_in        = wait_ff;
      access_kind_in = access_kind_ff;
      address_in     = address_ff;
      register_in    = register_ff;
      data_in        = data_ff;
      received_in    = received_ff;
      error_in       = error_ff;
      scl            = 1'b1;
      sda            = 1'b1;
      done           = 1'b0;

      case (phase_ff)
         i2cmra_pkg::PH_START: begin
            sda          = 1'b0;
            shift_in     = address_ff;
            bit_count_in = '0;
            group_in     = i2cmra_pkg::GRP_ADDR;
            phase_in     = i2cmra_pkg::PH_BIT_LO;
         end
         i2cmra_pkg::PH_BIT_LO: begin
            scl      = 1'b0;
            sda      = shift_ff[7];
            phase_in = i2cmra_pkg::PH_BIT_HI;
         end
         i2cmra_pkg::PH_BIT_HI: begin
            sda          = shift_ff[7];
            shift_in     = {shift_ff[6:0], 1'b0};
            bit_count_in = bit_count_ff + 3'd1;
            phase_in     = (bit_count_ff == i2cmra_pkg::LAST_BIT) ? i2cmra_pkg::PH_ACK_LO
                                                                  : i2cmra_pkg::PH_BIT_LO;
         end
         i2cmra_pkg::PH_ACK_LO: begin
            scl      = 1'b0;
            wait_in  = '0;
            phase_in = i2cmra_pkg::PH_ACK_HI;
         end
         i2cmra_pkg::PH_ACK_HI: begin
            if (!item.sda_in) begin
               case (group_ff)
                  i2cmra_pkg::GRP_ADDR: begin
                     shift_in     = register_ff;
                     bit_count_in = '0;
                     group_in     = i2cmra_pkg::GRP_REG;
                     phase_in     = i2cmra_pkg::PH_BIT_LO;
                  end
                  i2cmra_pkg::GRP_REG: begin
                     if (access_kind_ff == i2cmra_pkg::KIND_READ) begin
                        phase_in = i2cmra_pkg::PH_RS_LO;
                     end else if (access_kind_ff == i2cmra_pkg::KIND_WRITE) begin
                        shift_in     = data_ff;
                        bit_count_in = '0;
                        group_in     = i2cmra_pkg::GRP_DATA;
                        phase_in     = i2cmra_pkg::PH_BIT_LO;
                     end else begin
                        phase_in = i2cmra_pkg::PH_SP_LO;
                     end
                  end
                  i2cmra_pkg::GRP_RADDR: begin
                     shift_in     = '0;
                     bit_count_in = '0;
                     phase_in     = i2cmra_pkg::PH_RD_LO;
                  end
                  default: begin
                     phase_in = i2cmra_pkg::PH_SP_LO;
                  end
               endcase
            end else begin
               wait_in = wait_inc;
               if (wait_inc >= ack_timeout) begin
                  error_in    = 1'b1;
                  received_in = '0;
                  phase_in    = i2cmra_pkg::PH_SP_LO;
               end
            end
         end
         i2cmra_pkg::PH_RS_LO: begin
            scl      = 1'b0;
            phase_in = i2cmra_pkg::PH_RS_HI;
         end
         i2cmra_pkg::PH_RS_HI: begin
            phase_in = i2cmra_pkg::PH_RS_FALL;
         end
         i2cmra_pkg::PH_RS_FALL: begin
            sda          = 1'b0;
            shift_in     = address_ff + 8'd1;
            bit_count_in = '0;
            group_in     = i2cmra_pkg::GRP_RADDR;
            phase_in     = i2cmra_pkg::PH_BIT_LO;
         end
         i2cmra_pkg::PH_RD_LO: begin
            scl      = 1'b0;
            phase_in = i2cmra_pkg::PH_RD_HI;
         end
         i2cmra_pkg::PH_RD_HI: begin
            shift_in     = shift_rd;
            bit_count_in = bit_count_ff + 3'd1;
            if (bit_count_ff == i2cmra_pkg::LAST_BIT) begin
               received_in = shift_rd;
               phase_in    = i2cmra_pkg::PH_NK_LO;
            end else begin
               phase_in = i2cmra_pkg::PH_RD_LO;
            end
         end
         i2cmra_pkg::PH_NK_LO: begin
            scl      = 1'b0;
            phase_in = i2cmra_pkg::PH_NK_HI;
         end
         i2cmra_pkg::PH_NK_HI: begin
            phase_in = i2cmra_pkg::PH_SP_LO;
         end
         i2cmra_pkg::PH_SP_LO: begin
            scl      = 1'b0;
            sda      = 1'b0;
            phase_in = i2cmra_pkg::PH_SP_HI;
         end
         i2cmra_pkg::PH_SP_HI: begin
            sda      = 1'b0;
            phase_in = i2cmra_pkg::PH_SP_RISE;
         end
         i2cmra_pkg::PH_SP_RISE: begin
            done     = 1'b1;
            phase_in = i2cmra_pkg::PH_IDLE;
         end
         default: begin
            // idle: lines released, take a new command
            phase_in = i2cmra_pkg::PH_IDLE;
            if (item.kind != i2cmra_pkg::KIND_TICK) begin
               access_kind_in = item.kind;
               address_in     = item.device_address;
               register_in    = item.register_index;
               data_in        = item.write_data;
               error_in       = 1'b0;
               wait_in        = '0;
               bit_count_in   = '0;
               phase_in       = i2cmra_pkg::PH_START;
            end
         end
      endcase
   end

   always_comb begin
      result.scl_out     = scl;
      result.sda_out     = sda;
      result.busy_res    = (phase_in != i2cmra_pkg::PH_IDLE);
      result.done_res    = done;
      result.read_data   = received_in;
      result.ack_missing = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= i2cmra_pkg::PH_IDLE;
         group_ff       <= '0;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         wait_ff        <= '0;
         access_kind_ff <= '0;
         address_ff     <= '0;
         register_ff    <= '0;
         data_ff        <= '0;
         received_ff    <= '0;
         error_ff       <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         group_ff       <= group_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         wait_ff        <= wait_in;
         access_kind_ff <= access_kind_in;
         address_ff     <= address_in;
         register_ff    <= register_in;
         data_ff        <= data_in;
         received_ff    <= received_in;
         error_ff       <= error_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/i2c_master_register_access.sv
// ---------------------------------------------------------------------------
// I2C master register access
// Bit-level I2C master for register read, write and command-only accesses,
// advanced one bus phase per tick transfer.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    kind, device_address, register_index,
//                                 write_data, sda_in
//   rsp_chan  out  valid/ready    scl_out, sda_out, busy_res, done_res,
//                                 read_data, ack_missing
//   csr_chan  in   valid/ready    data (ack_timeout, 16 bit)
//
// Path: a tick transfer lands in the input register, is stepped through
// the phase logic and loads the result register, which offers its result.
// Throughput: one tick per cycle while rsp_chan.ready stays high; the bus
// phase state is updated in the same cycle its result is registered, so
// the next tick sees it directly.
// Stalls: rsp_chan.ready low holds the result register, and the input
// register fills and then drops req_chan.ready. csr_chan is always ready.
// Reset: synchronous; bus idle, lines released, ack_timeout = 1000.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access (
   input  logic          clock,
   input  logic          reset,
   i2cmra_req_if.sink    req_chan,
   i2cmra_rsp_if.source  rsp_chan,
   i2cmra_csr_if.sink    csr_chan
);

   // input register
   logic                     in_valid_ff;
   i2cmra_pkg::req_item_type in_item_ff;
   i2cmra_pkg::req_item_type req_item;

   // result register
   logic                     out_valid_ff;
   i2cmra_pkg::rsp_item_type out_item_ff;
   i2cmra_pkg::rsp_item_type step_result;

   logic [15:0] ack_timeout_ff;
   logic        advance;
   logic        req_take;

   // move the held tick into the result stage when the result slot frees up
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      req_item.kind           = req_chan.kind;
      req_item.device_address = req_chan.device_address;
      req_item.register_index = req_chan.register_index;
      req_item.write_data     = req_chan.write_data;
      req_item.sda_in         = req_chan.sda_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= i2cmra_pkg::TIMEOUT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         ack_timeout_ff <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   i2cmra_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .ack_timeout (ack_timeout_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.scl_out     = out_item_ff.scl_out;
   assign rsp_chan.sda_out     = out_item_ff.sda_out;
   assign rsp_chan.busy_res    = out_item_ff.busy_res;
   assign rsp_chan.done_res    = out_item_ff.done_res;
   assign rsp_chan.read_data   = out_item_ff.read_data;
   assign rsp_chan.ack_missing = out_item_ff.ack_missing;

endmodule

`default_nettype wire

// File: sv/i2cmra_checker.sv
// ---------------------------------------------------------------------------
// I2C register access checker
// Port-level assertions on the result channel of the I2C master.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2cmra_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_out,
   input logic       rsp_sda_out,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_ack_missing
);

   // a stalled result transfer keeps its payload
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_scl_out) && $stable(rsp_sda_out) && $stable(rsp_read_data),
      "result changed while stalled")

   // stop completes with both lines released and the bus idle
   `CHK_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_done_res,
      !rsp_busy_res && rsp_scl_out && rsp_sda_out, "done without idle released bus")

   // clock is only pulled low in the middle of an access
   `CHK_IMPLY(a_scl_low_busy, clock, reset, rsp_valid && !rsp_scl_out, rsp_busy_res,
      "scl low while idle")

   // an aborted access clears the read byte
   `CHK_IMPLY(a_abort_clear, clock, reset, rsp_valid && rsp_ack_missing,
      rsp_read_data == 8'd0, "read data kept after abort")

endmodule

bind i2c_master_register_access i2cmra_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_scl_out     (rsp_chan.scl_out),
   .rsp_sda_out     (rsp_chan.sda_out),
   .rsp_busy_res    (rsp_chan.busy_res),
   .rsp_done_res    (rsp_chan.done_res),
   .rsp_read_data   (rsp_chan.read_data),
   .rsp_ack_missing (rsp_chan.ack_missing)
);

`default_nettype wire

// File: verif/tb_i2c_master_register_access.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master register access testbench
// Feeds bus phase ticks and commands through the request channel and checks
// every per-tick result against a cycle-free model of the bus sequencer.
// The stimulus is planned access by access on a second copy of that model,
// which tells it where the acknowledge and read phases fall. It runs with
// several ack timeout settings, including 1 and the 16-bit maximum 65535.
// ---------------------------------------------------------------------------

module tb_i2c_master_register_access;
   import i2cmra_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int HOLD_CYCLES     = 240;

   // Bus sequencer state as seen from the pins; one copy plans stimulus,
   // one copy predicts what the block returns.
   typedef struct packed {
      phase_type   ph;
      logic [1:0]  grp;      // byte being sent, GRP_*
      logic [2:0]  nbits;
      logic [7:0]  shreg;
      logic [15:0] waited;   // high-clock ack ticks seen with sda high
      logic [1:0]  op;       // KIND_* of the access in progress
      logic [7:0]  addr;
      logic [7:0]  regi;
      logic [7:0]  wdata;
      logic [7:0]  rx;       // last byte read
      logic        scl;
      logic        sda;
      logic        err;
      logic [15:0] timeout;
   } bus_state_t;

   logic clock;
   logic reset;

   i2cmra_req_if req_chan ();
   i2cmra_rsp_if rsp_chan ();
   i2cmra_csr_if csr_chan ();

   i2c_master_register_access DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   req_item_type pending_ticks[$];   // planned, not yet offered
   rsp_item_type expected_lines[$];  // predicted pin results, oldest first

   bus_state_t   plan_bus;   // advanced when a tick is planned
   bus_state_t   live_bus;   // advanced when a tick transfer is accepted
   req_item_type on_wire;

   int burst_left;
   int gap_left;
   int hold_left;
   bit hold_done;
   int stall_mode;
   int rsp_seen;
   int cycles;
   int mismatches;
   int items_queued;

   // -----------------------------------------------------------------------
   // Bus sequencer model
   // -----------------------------------------------------------------------
   function automatic bus_state_t bus_reset_state();
      bus_state_t s;
      s         = '0;
      s.ph      = PH_IDLE;
      s.scl     = 1'b1;
      s.sda     = 1'b1;
      s.timeout = TIMEOUT_RESET;
      return s;
   endfunction

   function automatic void load_byte(inout bus_state_t s, input logic [1:0] g,
                                     input logic [7:0] v);
      s.shreg = v;
      s.nbits = '0;
      s.grp   = g;
      s.ph    = PH_BIT_LO;
   endfunction

   function automatic void bus_step(inout bus_state_t s, input req_item_type it,
                                    output rsp_item_type r);
      logic done;
      done = 1'b0;
      case (s.ph)
         PH_START: begin
            s.scl = 1'b1; s.sda = 1'b0;
            load_byte(s, GRP_ADDR, s.addr);
         end
         PH_BIT_LO: begin
            s.scl = 1'b0; s.sda = s.shreg[7];
            s.ph  = PH_BIT_HI;
         end
         PH_BIT_HI: begin
            s.scl   = 1'b1; s.sda = s.shreg[7];
            s.shreg = {s.shreg[6:0], 1'b0};
            s.ph    = (s.nbits == LAST_BIT) ? PH_ACK_LO : PH_BIT_LO;
            s.nbits = s.nbits + 3'd1;
         end
         PH_ACK_LO: begin
            s.scl    = 1'b0; s.sda = 1'b1;
            s.waited = '0;
            s.ph     = PH_ACK_HI;
         end
         PH_ACK_HI: begin
            s.scl = 1'b1; s.sda = 1'b1;
            if (!it.sda_in) begin
               case (s.grp)
                  GRP_ADDR: load_byte(s, GRP_REG, s.regi);
                  GRP_REG: begin
                     if (s.op == KIND_READ)       s.ph = PH_RS_LO;
                     else if (s.op == KIND_WRITE) load_byte(s, GRP_DATA, s.wdata);
                     else                         s.ph = PH_SP_LO;
                  end
                  GRP_RADDR: begin
                     s.shreg = '0;
                     s.nbits = '0;
                     s.ph    = PH_RD_LO;
                  end
                  default: s.ph = PH_SP_LO;
               endcase
            end else begin
               s.waited = s.waited + 16'd1;
               if (s.waited >= s.timeout) begin
                  s.err = 1'b1;
                  s.rx  = '0;
                  s.ph  = PH_SP_LO;
               end
            end
         end
         PH_RS_LO:   begin s.scl = 1'b0; s.sda = 1'b1; s.ph = PH_RS_HI;   end
         PH_RS_HI:   begin s.scl = 1'b1; s.sda = 1'b1; s.ph = PH_RS_FALL; end
         PH_RS_FALL: begin
            s.scl = 1'b1; s.sda = 1'b0;
            load_byte(s, GRP_RADDR, s.addr + 8'd1);
         end
         PH_RD_LO:   begin s.scl = 1'b0; s.sda = 1'b1; s.ph = PH_RD_HI; end
         PH_RD_HI: begin
            s.scl   = 1'b1; s.sda = 1'b1;
            s.shreg = {s.shreg[6:0], it.sda_in};
            if (s.nbits == LAST_BIT) begin
               s.rx = s.shreg;
               s.ph = PH_NK_LO;
            end else begin
               s.ph = PH_RD_LO;
            end
            s.nbits = s.nbits + 3'd1;
         end
         PH_NK_LO:   begin s.scl = 1'b0; s.sda = 1'b1; s.ph = PH_NK_HI;   end
         PH_NK_HI:   begin s.scl = 1'b1; s.sda = 1'b1; s.ph = PH_SP_LO;   end
         PH_SP_LO:   begin s.scl = 1'b0; s.sda = 1'b0; s.ph = PH_SP_HI;   end
         PH_SP_HI:   begin s.scl = 1'b1; s.sda = 1'b0; s.ph = PH_SP_RISE; end
         PH_SP_RISE: begin
            s.scl = 1'b1; s.sda = 1'b1;
            done  = 1'b1;
            s.ph  = PH_IDLE;
         end
         default: begin
            // idle: a command starts an access, a plain tick does nothing
            s.scl = 1'b1; s.sda = 1'b1;
            s.ph  = PH_IDLE;
            if (it.kind != KIND_TICK) begin
               s.op     = it.kind;
               s.addr   = it.device_address;
               s.regi   = it.register_index;
               s.wdata  = it.write_data;
               s.err    = 1'b0;
               s.waited = '0;
               s.nbits  = '0;
               s.ph     = PH_START;
            end
         end
      endcase
      r.scl_out     = s.scl;
      r.sda_out     = s.sda;
      r.busy_res    = (s.ph != PH_IDLE);
      r.done_res    = done;
      r.read_data   = s.rx;
      r.ack_missing = s.err;
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus planning (zero time)
   // -----------------------------------------------------------------------
   task automatic queue_tick(input req_item_type it);
      rsp_item_type unused;
      pending_ticks.push_back(it);
      bus_step(plan_bus, it, unused);
      items_queued++;
   endtask

   // One whole access, from the command to the end of stop. abort_ack picks
   // which acknowledge (0 = address) is left high until timeout; -1 for none.
   task automatic queue_access(input logic [1:0] op, input logic [7:0] a, input logic [7:0] r,
                               input logic [7:0] d, input int abort_ack);
      req_item_type it;
      int ack_no;
      int delay;
      int lim;
      ack_no = 0;
      delay  = 0;
      it.kind           = op;
      it.device_address = a;
      it.register_index = r;
      it.write_data     = d;
      it.sda_in         = 1'($urandom);
      queue_tick(it);
      while (plan_bus.ph != PH_IDLE) begin
         // mostly plain ticks; now and then a command the busy master must ignore
         it.kind           = ($urandom_range(7, 0) == 0) ? 2'($urandom_range(3, 1)) : KIND_TICK;
         it.device_address = 8'($urandom);
         it.register_index = 8'($urandom);
         it.write_data     = 8'($urandom);
         it.sda_in         = 1'($urandom);
         if (plan_bus.ph == PH_ACK_LO) begin
            // decide how long the slave keeps sda high on this acknowledge
            if (ack_no == abort_ack) begin
               delay = plan_bus.timeout;
            end else begin
               lim = (plan_bus.timeout > 16'd4) ? 4 : int'(plan_bus.timeout) - 1;
               case ($urandom_range(3, 0))
                  0, 1:    delay = 0;
                  2:       delay = $urandom_range(lim, 0);
                  default: delay = (plan_bus.timeout <= 16'd40) ? int'(plan_bus.timeout) - 1 : lim;
               endcase
            end
            ack_no++;
         end
         if (plan_bus.ph == PH_ACK_HI) it.sda_in = (int'(plan_bus.waited) < delay);
         queue_tick(it);
      end
   endtask

   task automatic queue_random_phase(input int target);
      req_item_type it;
      int abort_ack;
      int idles;
      while (items_queued < target) begin
         abort_ack = -1;
         if (plan_bus.timeout <= 16'd64 && $urandom_range(4, 0) == 0)
            abort_ack = $urandom_range(2, 0);
         queue_access(2'($urandom_range(3, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                      abort_ack);
         idles = $urandom_range(3, 0);
         repeat (idles) begin
            it.kind           = KIND_TICK;
            it.device_address = 8'($urandom);
            it.register_index = 8'($urandom);
            it.write_data     = 8'($urandom);
            it.sda_in         = 1'($urandom);
            queue_tick(it);
         end
      end
   endtask

   // The sender pauses here until every predicted result has come back.
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_chan.valid || expected_lines.size() != 0)
         @(posedge clock);
   endtask

   // Only called with the bus model idle and nothing in flight.
   task automatic write_timeout(input logic [15:0] v);
      plan_bus.timeout = v;
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      do @(posedge clock); while (!csr_chan.ready);
      live_bus.timeout = v;
      csr_chan.valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // -----------------------------------------------------------------------
   // Clock
   // -----------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps between them.
   // The prediction is advanced on the transfer itself, so stalls and gaps
   // never disturb the order of expected results.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type predicted;
      if (reset) begin
         req_chan.valid <= 1'b0;
         live_bus   = bus_reset_state();
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            bus_step(live_bus, on_wire, predicted);
            expected_lines.push_back(predicted);
         end
         // the slot is free once the current tick has transferred
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               on_wire = pending_ticks.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.kind           <= on_wire.kind;
               req_chan.device_address <= on_wire.device_address;
               req_chan.register_index <= on_wire.register_index;
               req_chan.write_data     <= on_wire.write_data;
               req_chan.sda_in         <= on_wire.sda_in;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40, 1);
                  gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Result receiver: stall pattern changes now and then; once, while ticks
   // are still waiting, it holds off long enough to back up the request side.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
         stall_mode = 0;
      end else begin
         if (!hold_done && rsp_seen > 100 && pending_ticks.size() > 40) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if ($urandom_range(63, 0) == 0) stall_mode = $urandom_range(3, 0);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(3, 0) != 0);
               2:       rsp_chan.ready <= (cycles % 5 != 0);
               default: rsp_chan.ready <= 1'($urandom);
            endcase
         end
      end
   end

   // -----------------------------------------------------------------------
   // Result monitor: each result transfer against the oldest prediction
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_seen++;
         if (expected_lines.size() == 0) begin
            $error("result transfer with no tick outstanding");
            mismatches++;
         end else begin
            want = expected_lines.pop_front();
            check_field("scl_out", want.scl_out, rsp_chan.scl_out);
            check_field("sda_out", want.sda_out, rsp_chan.sda_out);
            check_field("busy_res", want.busy_res, rsp_chan.busy_res);
            check_field("done_res", want.done_res, rsp_chan.done_res);
            check_field("read_data", want.read_data, rsp_chan.read_data);
            check_field("ack_missing", want.ack_missing, rsp_chan.ack_missing);
         end
      end
   end

   // -----------------------------------------------------------------------
   // Watchdog
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("i2c_master_register_access: mismatch");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Sequence: reset value first, then a range of timeout settings. Between
   // settings the bus model is idle and every result has come back.
   // -----------------------------------------------------------------------
   initial begin
      req_item_type it;
      int settings[6];
      int phase_no;
      cycles       = 0;
      mismatches   = 0;
      rsp_seen     = 0;
      items_queued = 0;
      req_chan.valid          = 1'b0;
      req_chan.kind           = KIND_TICK;
      req_chan.device_address = '0;
      req_chan.register_index = '0;
      req_chan.write_data     = '0;
      req_chan.sda_in         = 1'b0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.data           = '0;
      plan_bus = bus_reset_state();
      reset    = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // idle ticks with all fields at both ends; nothing should move
      it = '{KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0};
      queue_tick(it);
      it = '{KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1};
      queue_tick(it);
      queue_random_phase(ITEMS_PER_PHASE);
      wait_drained();

      settings = '{1, 65535, 2, $urandom_range(12, 3), 300, $urandom_range(64, 13)};
      phase_no = 2;
      foreach (settings[k]) begin
         write_timeout(16'(settings[k]));
         if (settings[k] == 1) begin
            // shortest timeout: a read whose address is never acknowledged,
            // aborted on the first high ack tick
            queue_access(KIND_READ, 8'hFF, 8'h00, 8'hFF, 0);
         end
         queue_random_phase(ITEMS_PER_PHASE * phase_no);
         wait_drained();
         phase_no++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_lines.size() != 0) begin
         $error("%0d results never arrived", expected_lines.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("i2c_master_register_access: match");
      end else begin
         $display("i2c_master_register_access: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/i2cmra_pkg.sv
sv/i2cmra_if.sv
sv/i2cmra_engine.sv
sv/i2c_master_register_access.sv
sv/i2cmra_checker.sv
verif/tb_i2c_master_register_access.sv
